// ===== hw/rtl/mips_subset_instruction_executor_core_macros.svh =====
// ============================================================================
// Assertion macros for the MIPS subset instruction executor
// Shared property shorthands used by the RTL.
// ============================================================================
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MIPSX_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MIPSX_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/mipsx_pkg.sv =====
// ============================================================================
// MIPS subset executor package
// Constants and opcode codes shared by the executor RTL.
// ============================================================================
package mipsx_pkg;

    localparam int DATA_WORDS = 1024;
    localparam int DW_BITS    = $clog2(DATA_WORDS);

    localparam logic [31:0] PC_RESET  = 32'h0040_0000;
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [31:0] DATA_WORDS_W = 32'(DATA_WORDS);

    localparam int IN_BITS  = 80;
    localparam int OUT_BITS = 176;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    typedef struct packed {
        logic [31:0] executed_pc;
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_value;
        logic        branch_taken;
        logic        illegal;
        logic        mem_out_of_range;
    } result_t;

endpackage

// ===== hw/rtl/mips_subset_instruction_executor_core.sv =====
// ============================================================================
// MIPS subset instruction executor core
// Executes one MIPS instruction or data preload per transfer.
// ============================================================================
// Each input transfer yields one output transfer. The register file is read
// as an input transfer is taken; the item then passes through two stages
// (execute with the data memory read, then memory access and write-back)
// and an output register. One item is taken every cycle unless the output
// is stalled; the result transfer follows once the item has passed the
// s1, s2 and output registers. The register file and the data memory
// are synchronous memories; results still in flight are forwarded so
// back-to-back dependent instructions need no stall cycles. A data word must
// be preloaded or stored before it is read.
`include "mips_subset_instruction_executor_core_macros.svh"

module mips_subset_instruction_executor_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // instruction_word, preload_index, preload_value, zero pad
    input  logic [mipsx_pkg::IN_BITS-1:0]     s_tdata,
    // operation
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // executed_pc, next_pc, reg_write, reg_index, reg_value, mem_write,
    // mem_address, mem_value, branch_taken, illegal, mem_out_of_range, zero pad
    output logic [mipsx_pkg::OUT_BITS-1:0]    m_tdata
);

    localparam int DWB = mipsx_pkg::DW_BITS;

    logic [31:0] rf_mem [32];
    logic [31:0] dm_mem [mipsx_pkg::DATA_WORDS];
    logic [31:0] rf_valid_reg;

    logic        s1_v_reg, s2_v_reg, out_v_reg;
    logic        en1, en2, en_out, acc, s1_fire, s2_fire;

    logic        s1_pre_reg;
    logic [31:0] s1_ins_reg, s1_pval_reg;
    logic [9:0]  s1_pidx_reg;
    logic [31:0] rf_rs_q_reg, rf_rt_q_reg;
    logic [31:0] pc_reg;

    logic        lw_v_reg;
    logic [4:0]  lw_idx_reg;
    logic [31:0] lw_val_reg;

    logic           lm_v_reg;
    logic [DWB-1:0] lm_idx_reg;
    logic [31:0]    lm_val_reg;

    logic [31:0] s2_pc_reg, s2_nxt_reg, s2_val_reg, s2_maddr_reg, s2_rt_reg;
    logic [31:0] s2_pval_reg, dm_q_reg;
    logic [4:0]  s2_dest_reg;
    logic [1:0]  s2_lane_reg;
    logic [DWB-1:0] s2_midx_reg, s2_pidx_reg;
    logic        s2_wr_reg, s2_ld_reg, s2_lb_reg, s2_st_reg, s2_sb_reg, s2_inr_reg;
    logic        s2_taken_reg, s2_bad_reg, s2_pre_reg, s2_pok_reg;

    mipsx_pkg::result_t out_reg, res;

    assign en_out  = !out_v_reg || m_tready;
    assign en2     = !s2_v_reg || en_out;
    assign en1     = !s1_v_reg || en2;
    assign s2_fire = s2_v_reg && en_out;
    assign s1_fire = s1_v_reg && en2;
    assign s_tready = en1;
    assign acc     = s_tvalid && en1;

    // Write-back stage values
    logic [31:0] w2, byte_sx, merged, val2, mval2;
    logic        wr2, mw2, oor2, dm_we;
    logic [7:0]  bsel;
    logic [DWB-1:0] dm_wa;
    logic [31:0] dm_wd;

    always_comb
    begin
        w2 = (lm_v_reg && lm_idx_reg == s2_midx_reg) ? lm_val_reg : dm_q_reg;
        unique case (s2_lane_reg)
            2'd0: bsel = w2[31:24];
            2'd1: bsel = w2[23:16];
            2'd2: bsel = w2[15:8];
            default: bsel = w2[7:0];
        endcase
        byte_sx = {{24{bsel[7]}}, bsel};
        unique case (s2_lane_reg)
            2'd0: merged = {s2_rt_reg[7:0], w2[23:0]};
            2'd1: merged = {w2[31:24], s2_rt_reg[7:0], w2[15:0]};
            2'd2: merged = {w2[31:16], s2_rt_reg[7:0], w2[7:0]};
            default: merged = {w2[31:8], s2_rt_reg[7:0]};
        endcase
        val2  = s2_val_reg;
        mval2 = '0;
        mw2   = 1'b0;
        oor2  = 1'b0;
        if (s2_ld_reg)
        begin
            oor2 = !s2_inr_reg;
            val2 = !s2_inr_reg ? 32'd0 : (s2_lb_reg ? byte_sx : w2);
        end
        if (s2_st_reg)
        begin
            oor2  = !s2_inr_reg;
            mw2   = s2_inr_reg;
            mval2 = !s2_inr_reg ? 32'd0 : (s2_sb_reg ? merged : s2_rt_reg);
        end
        wr2 = s2_wr_reg && s2_dest_reg != 5'd0;
        res.executed_pc      = s2_pc_reg;
        res.next_pc          = s2_nxt_reg;
        res.reg_write        = wr2;
        res.reg_index        = wr2 ? s2_dest_reg : 5'd0;
        res.reg_value        = wr2 ? val2 : 32'd0;
        res.mem_write        = mw2;
        res.mem_address      = s2_maddr_reg;
        res.mem_value        = mval2;
        res.branch_taken     = s2_taken_reg;
        res.illegal          = s2_bad_reg;
        res.mem_out_of_range = oor2;
        dm_we = s2_fire && (mw2 || (s2_pre_reg && s2_pok_reg));
        dm_wa = s2_pre_reg ? s2_pidx_reg : s2_midx_reg;
        dm_wd = s2_pre_reg ? s2_pval_reg : mval2;
    end

    // Execute stage
    logic [5:0]  op, fn;
    logic [4:0]  rsi, rti, rdi, sh;
    logic [15:0] imm;
    logic [31:0] simm, rs, rt, ea, off, pc4, nxt1, val1, maddr1, pidx32;
    logic [4:0]  dest1;
    logic        wr1, ld1, lb1, st1, sb1, taken1, bad1, inr1;

    function automatic logic [31:0] rd_fwd(
        input logic [4:0]  idx,
        input logic [31:0] q,
        input logic        s2v,
        input logic        s2w,
        input logic [4:0]  s2d,
        input logic [31:0] s2val,
        input logic        lwv,
        input logic [4:0]  lwi,
        input logic [31:0] lwval,
        input logic [31:0] vbits
    );
        logic [31:0] r;
        if (idx == 5'd0)
            r = 32'd0;
        else if (s2v && s2w && s2d == idx)
            r = s2val;
        else if (lwv && lwi == idx)
            r = lwval;
        else if (vbits[idx])
            r = q;
        else
            r = 32'd0;
        return r;
    endfunction

    always_comb
    begin
        op   = s1_ins_reg[31:26];
        fn   = s1_ins_reg[5:0];
        rsi  = s1_ins_reg[25:21];
        rti  = s1_ins_reg[20:16];
        rdi  = s1_ins_reg[15:11];
        sh   = s1_ins_reg[10:6];
        imm  = s1_ins_reg[15:0];
        simm = {{16{imm[15]}}, imm};
        rs = rd_fwd(rsi, rf_rs_q_reg, s2_v_reg, wr2, s2_dest_reg, val2,
                    lw_v_reg, lw_idx_reg, lw_val_reg, rf_valid_reg);
        rt = rd_fwd(rti, rf_rt_q_reg, s2_v_reg, wr2, s2_dest_reg, val2,
                    lw_v_reg, lw_idx_reg, lw_val_reg, rf_valid_reg);
        ea   = rs + simm;
        off  = ea - mipsx_pkg::DATA_BASE;
        inr1 = (ea >= mipsx_pkg::DATA_BASE) && ({2'b00, off[31:2]} < mipsx_pkg::DATA_WORDS_W);
        pc4  = pc_reg + 32'd4;
        pidx32 = 32'(s1_pidx_reg);
        nxt1 = pc4;
        wr1 = 1'b0; dest1 = rti; val1 = '0;
        ld1 = 1'b0; lb1 = 1'b0; st1 = 1'b0; sb1 = 1'b0;
        taken1 = 1'b0; bad1 = 1'b0;
        maddr1 = {ea[31:2], 2'b00};
        unique case (op)
            mipsx_pkg::OP_SPECIAL:
            begin
                wr1   = 1'b1;
                dest1 = rdi;
                unique case (fn)
                    mipsx_pkg::FN_ADDU: val1 = rs + rt;
                    mipsx_pkg::FN_SUBU: val1 = rs - rt;
                    mipsx_pkg::FN_AND:  val1 = rs & rt;
                    mipsx_pkg::FN_OR:   val1 = rs | rt;
                    mipsx_pkg::FN_NOR:  val1 = ~(rs | rt);
                    mipsx_pkg::FN_SLTU: val1 = {31'd0, rs < rt};
                    mipsx_pkg::FN_SLL:  val1 = rt << sh;
                    mipsx_pkg::FN_SRL:  val1 = rt >> sh;
                    mipsx_pkg::FN_JR:
                    begin
                        wr1 = 1'b0; nxt1 = rs; taken1 = 1'b1;
                    end
                    default:
                    begin
                        wr1 = 1'b0; bad1 = 1'b1;
                    end
                endcase
            end
            mipsx_pkg::OP_ADDIU: begin wr1 = 1'b1; val1 = rs + simm; end
            mipsx_pkg::OP_ANDI:  begin wr1 = 1'b1; val1 = rs & {16'd0, imm}; end
            mipsx_pkg::OP_ORI:   begin wr1 = 1'b1; val1 = rs | {16'd0, imm}; end
            mipsx_pkg::OP_SLTIU: begin wr1 = 1'b1; val1 = {31'd0, rs < simm}; end
            mipsx_pkg::OP_LUI:   begin wr1 = 1'b1; val1 = {imm, 16'd0}; end
            mipsx_pkg::OP_BEQ, mipsx_pkg::OP_BNE:
            begin
                if ((rs == rt) == (op == mipsx_pkg::OP_BEQ))
                begin
                    nxt1 = pc4 + {simm[29:0], 2'b00};
                    taken1 = 1'b1;
                end
            end
            mipsx_pkg::OP_J, mipsx_pkg::OP_JAL:
            begin
                nxt1 = {pc4[31:28], s1_ins_reg[25:0], 2'b00};
                taken1 = 1'b1;
                if (op == mipsx_pkg::OP_JAL)
                begin
                    wr1 = 1'b1; dest1 = 5'd31; val1 = pc4;
                end
            end
            mipsx_pkg::OP_LW, mipsx_pkg::OP_LB:
            begin
                wr1 = 1'b1; ld1 = 1'b1; lb1 = (op == mipsx_pkg::OP_LB);
            end
            mipsx_pkg::OP_SW, mipsx_pkg::OP_SB:
            begin
                st1 = 1'b1; sb1 = (op == mipsx_pkg::OP_SB);
            end
            default: bad1 = 1'b1;
        endcase
        if (!ld1 && !st1)
            maddr1 = '0;
        if (s1_pre_reg)
        begin
            nxt1 = pc_reg; wr1 = 1'b0; ld1 = 1'b0; st1 = 1'b0;
            taken1 = 1'b0; bad1 = 1'b0; maddr1 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            pc_reg       <= mipsx_pkg::PC_RESET;
            rf_valid_reg <= '0;
            lw_v_reg     <= 1'b0;
            lm_v_reg     <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_v_reg <= s_tvalid;
            if (en2)
                s2_v_reg <= s1_v_reg;
            if (en_out)
                out_v_reg <= s2_v_reg;
            if (s1_fire)
                pc_reg <= nxt1;
            if (s2_fire)
            begin
                lw_v_reg <= wr2;
                lm_v_reg <= dm_we;
                if (wr2)
                    rf_valid_reg[s2_dest_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_pre_reg  <= s_tuser;
            s1_ins_reg  <= s_tdata[31:0];
            s1_pidx_reg <= s_tdata[41:32];
            s1_pval_reg <= s_tdata[73:42];
            rf_rs_q_reg <= rf_mem[s_tdata[25:21]];
            rf_rt_q_reg <= rf_mem[s_tdata[20:16]];
        end
        if (s1_fire)
        begin
            s2_pc_reg    <= pc_reg;
            s2_nxt_reg   <= nxt1;
            s2_wr_reg    <= wr1;
            s2_dest_reg  <= dest1;
            s2_val_reg   <= val1;
            s2_ld_reg    <= ld1;
            s2_lb_reg    <= lb1;
            s2_st_reg    <= st1;
            s2_sb_reg    <= sb1;
            s2_inr_reg   <= inr1;
            s2_lane_reg  <= ea[1:0];
            s2_maddr_reg <= maddr1;
            s2_rt_reg    <= rt;
            s2_taken_reg <= taken1;
            s2_bad_reg   <= bad1;
            s2_pre_reg   <= s1_pre_reg;
            s2_pok_reg   <= pidx32 < mipsx_pkg::DATA_WORDS_W;
            s2_pidx_reg  <= pidx32[DWB-1:0];
            s2_pval_reg  <= s1_pval_reg;
            s2_midx_reg  <= off[DWB+1:2];
            dm_q_reg     <= dm_mem[off[DWB+1:2]];
        end
        if (s2_fire)
        begin
            out_reg    <= res;
            lw_idx_reg <= s2_dest_reg;
            lw_val_reg <= val2;
            lm_idx_reg <= dm_wa;
            lm_val_reg <= dm_wd;
            if (wr2)
                rf_mem[s2_dest_reg] <= val2;
            if (dm_we)
                dm_mem[dm_wa] <= dm_wd;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0,
                       out_reg.mem_out_of_range, out_reg.illegal, out_reg.branch_taken,
                       out_reg.mem_value, out_reg.mem_address, out_reg.mem_write,
                       out_reg.reg_value, out_reg.reg_index, out_reg.reg_write,
                       out_reg.next_pc, out_reg.executed_pc};

    `MIPSX_ASSERT_IMP(a_no_zero_write, clk, rst_n, s2_fire && wr2, s2_dest_reg != 5'd0)
    `MIPSX_ASSERT_NXT(a_pc_hold, clk, rst_n, !s1_fire, $stable(pc_reg))
    `MIPSX_ASSERT_IMP(a_store_legal, clk, rst_n, out_v_reg,
                      !(out_reg.mem_write && (out_reg.illegal || out_reg.mem_out_of_range)))
    `MIPSX_ASSERT_IMP(a_stall_chain, clk, rst_n, s_tready && s1_v_reg, en2)

endmodule
